// File: rtl/a85_pkg.sv
package a85_pkg;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_Z     = 8'h7A;

    localparam logic [31:0] DIGIT_BASE = 32'd85;
    localparam logic [2:0]  GROUP_LAST = 3'd4;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_END  = 2'd1,
        ST_LONE = 2'd2
    } t_status;

    // One decoded run: up to four bytes of word, high byte first.
    typedef struct packed {
        logic [31:0] word;
        logic        has_data;
        logic [1:0]  last_idx;
        t_status     status;
    } t_cmd;

    // Queue status seen by the producer and consumer sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // 85^k for the pad digits still missing: digits held 2, 3, 4 -> k 3, 2, 1.
    function automatic logic [19:0] pad_mult(input logic [1:0] held_minus_2);
        logic [19:0] m;
        case (held_minus_2)
            2'd0:    m = 20'd614125;
            2'd1:    m = 20'd7225;
            default: m = 20'd85;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/a85_front.sv
module a85_front
    import a85_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [31:0] r_value;
    logic [31:0] n_value;

    logic        is_space;
    logic        is_digit;
    logic        is_zero_grp;
    logic [31:0] digit_val;
    logic [31:0] acc_val;
    logic [31:0] pad_val;
    logic [1:0]  held_m2;

    assign is_space    = (i_text_char <= CHAR_SPACE);
    assign is_digit    = (i_text_char >= CHAR_BANG) && (i_text_char <= CHAR_U);
    assign is_zero_grp = (i_text_char == CHAR_Z) && (r_count == 3'd0);
    assign digit_val   = {24'd0, i_text_char - CHAR_BANG};
    assign acc_val     = r_value * DIGIT_BASE + digit_val;
    assign held_m2     = r_count[1:0] - 2'd2;
    // (v+1)*85^k - 1 equals padding with k digits of 84
    assign pad_val     = (r_value + 32'd1) * {12'd0, pad_mult(held_m2)} - 32'd1;

    always_comb begin
        n_count       = r_count;
        n_value       = r_value;
        o_cmd_push    = 1'b0;
        o_cmd         = '0;
        o_cmd.status  = ST_RUN;
        if (i_accept) begin
            if (!i_end_of_text && is_space) begin
                // skip
            end else if (!i_end_of_text && is_digit) begin
                if (r_count == GROUP_LAST) begin
                    o_cmd_push     = 1'b1;
                    o_cmd.word     = acc_val;
                    o_cmd.has_data = 1'b1;
                    o_cmd.last_idx = 2'd3;
                    n_count        = 3'd0;
                    n_value        = 32'd0;
                end else begin
                    n_count = r_count + 3'd1;
                    n_value = acc_val;
                end
            end else if (!i_end_of_text && is_zero_grp) begin
                o_cmd_push     = 1'b1;
                o_cmd.has_data = 1'b1;
                o_cmd.last_idx = 2'd3;
                n_value        = 32'd0;
            end else begin
                o_cmd_push = 1'b1;
                n_count    = 3'd0;
                n_value    = 32'd0;
                if (r_count == 3'd0) begin
                    o_cmd.status = ST_END;
                end else if (r_count == 3'd1) begin
                    o_cmd.status = ST_LONE;
                end else begin
                    o_cmd.word     = pad_val;
                    o_cmd.has_data = 1'b1;
                    o_cmd.last_idx = held_m2;
                    o_cmd.status   = ST_END;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_value <= 32'd0;
        end else begin
            r_count <= n_count;
            r_value <= n_value;
        end
    end

endmodule

// File: rtl/a85_cmdq.sv
module a85_cmdq
    import a85_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr;
    logic [CMDQ_AW-1:0]  r_rd;
    logic [CMDQ_AW:0]    r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + CMDQ_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (CMDQ_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (CMDQ_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/a85_back.sv
module a85_back
    import a85_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    input  logic       i_pop,
    output logic       o_cmd_pop,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic [1:0] o_end_status
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       is_last;
    logic       take;

    assign is_last       = (r_idx == i_head.last_idx);
    assign take          = i_pop && !i_empty;
    assign o_cmd_pop     = take && is_last;
    assign o_byte_valid  = i_head.has_data;
    assign o_last_of_run = is_last;
    assign o_end_status  = is_last ? i_head.status : ST_RUN;

    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = i_head.word[31:24];
            2'd1:    o_data_byte = i_head.word[23:16];
            2'd2:    o_data_byte = i_head.word[15:8];
            default: o_data_byte = i_head.word[7:0];
        endcase
        if (!i_head.has_data) begin
            o_data_byte = 8'd0;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx <= i_head.last_idx)
        else $error("byte index past end of run");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_head.has_data) |->
            (i_head.last_idx == 2'd0 && i_head.status != ST_RUN))
        else $error("status-only run malformed");

    a_run_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_head.status == ST_RUN) |-> i_head.has_data)
        else $error("running run without bytes");

    a_mid_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !is_last) |=> (!i_empty && r_idx == $past(r_idx) + 2'd1))
        else $error("run lost before its last byte");

endmodule

// File: rtl/ascii85_stream_decoder.sv
// Ascii85 stream decoder.
// Input channel: present one character on i_text_char (or raise i_end_of_text)
// with push; the item transfers on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result item sits on o_data_byte,
// o_byte_valid, o_last_of_run and o_end_status; it transfers on an edge with
// pop high. Each input causes zero to four result items; o_last_of_run marks
// the final one and o_end_status reports the end of a text there.
// Throughput: one character per cycle on input while full is low, one result
// item per cycle on output while pop is high and empty is low. A completed
// group or 'z' yields four items, so dense groups are bounded by the output side.
// Results of an item enter the run queue at its transfer, behind earlier runs.
// The front end classifies and accumulates (one 32-bit multiply for padding);
// a four-entry run queue decouples it from the byte serializer.
// Stall: when the receiver holds pop low, the queue fills and full rises;
// skipped characters and partial digits also wait for full to fall.
// Reset: synchronous, active low; clears the group and empties the queue.
module ascii85_stream_decoder
    import a85_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic [1:0] o_end_status
);

    t_cmd   front_cmd;
    logic   front_push;
    t_cmd   q_head;
    t_qstat q_stat;
    logic   back_pop;

    // Hold input while the run queue is full.
    assign full  = q_stat.full;
    assign empty = q_stat.empty;

    a85_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (push && !q_stat.full),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_cmd_push    (front_push),
        .o_cmd         (front_cmd)
    );

    a85_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Advance through the head run byte by byte; drop it after its last byte.
    a85_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_empty       (q_stat.empty),
        .i_pop         (pop),
        .o_cmd_pop     (back_pop),
        .o_data_byte   (o_data_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_end_status  (o_end_status)
    );

endmodule
